// ----- src/u16e_pkg.sv -----
// Package for the UTF-16 escape parser: payload structs, status codes,
// decoder state type and the hex digit helper. No dependencies.
`default_nettype none

package u16e_pkg;

  localparam logic [7:0]  CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0]  CHAR_U         = 8'h75;
  localparam logic [15:0] HI_START       = 16'hD800;
  localparam logic [15:0] LO_START       = 16'hDC00;
  localparam logic [15:0] LO_LAST        = 16'hDFFF;
  localparam logic [20:0] PAIR_BIAS      = 21'h10000;
  localparam logic [3:0]  COUNT_MAX      = 4'hF;

  // Character positions within "\uXXXX\uXXXX".
  localparam logic [3:0]  POS_BSL1       = 4'd0;
  localparam logic [3:0]  POS_U1         = 4'd1;
  localparam logic [3:0]  POS_HEX1_FIRST = 4'd2;
  localparam logic [3:0]  POS_HEX1_LAST  = 4'd5;
  localparam logic [3:0]  POS_BSL2       = 4'd6;
  localparam logic [3:0]  POS_U2         = 4'd7;
  localparam logic [3:0]  POS_HEX2_LAST  = 4'd11;
  localparam logic [3:0]  LEN_SINGLE     = 4'd6;
  localparam logic [3:0]  LEN_PAIR       = 4'd12;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_NO_BSL     = 3'd2,
    ST_NO_U       = 3'd3,
    ST_LONE_LOW   = 3'd4,
    ST_NO_SECOND  = 3'd5,
    ST_BAD_SECOND = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PFX_OK     = 2'd0,
    PFX_NO_BSL = 2'd1,
    PFX_NO_U   = 2'd2
  } prefix_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  char_count;
    logic [15:0] first_unit;
    logic [15:0] second_unit;
    prefix_t     first_prefix_status;
    logic        second_prefix_ok;
    logic        first_digit_bad;
    logic        second_digit_bad;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    char_count:          4'd0,
    first_unit:          16'h0000,
    second_unit:         16'h0000,
    first_prefix_status: PFX_OK,
    second_prefix_ok:    1'b1,
    first_digit_bad:     1'b0,
    second_digit_bad:    1'b0
  };

  // Bit 4 set means the byte is not a hex digit; the low nibble is then zero.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) v = {1'b0, 4'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) v = {1'b0, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) v = {1'b0, 4'(b - 8'h57)};
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- src/u16e_eval.sv -----
// Final checks of the UTF-16 escape parser: turns the decoder state after
// the last character into a code point and status. Uses u16e_pkg.
`default_nettype none

module u16e_eval (
  input  wire u16e_pkg::dec_state_t st,
  output u16e_pkg::out_item_t       res
);

  logic [15:0]       code1;
  logic [15:0]       code2;
  logic              is_low1;
  logic              is_high1;
  logic              is_low2;
  u16e_pkg::status_t status;
  logic [20:0]       cp;

  always_comb begin
    // A unit with a bad digit counts as zero.
    code1    = st.first_digit_bad  ? 16'h0000 : st.first_unit;
    code2    = st.second_digit_bad ? 16'h0000 : st.second_unit;
    is_low1  = (code1 >= u16e_pkg::LO_START) && (code1 <= u16e_pkg::LO_LAST);
    is_high1 = (code1 >= u16e_pkg::HI_START) && (code1 < u16e_pkg::LO_START);
    is_low2  = (code2 >= u16e_pkg::LO_START) && (code2 <= u16e_pkg::LO_LAST);
    status   = u16e_pkg::ST_OK;
    cp       = 21'd0;
    priority if (st.char_count < u16e_pkg::LEN_SINGLE) begin
      status = u16e_pkg::ST_SHORT;
    end else if (st.first_prefix_status == u16e_pkg::PFX_NO_BSL) begin
      status = u16e_pkg::ST_NO_BSL;
    end else if (st.first_prefix_status != u16e_pkg::PFX_OK) begin
      status = u16e_pkg::ST_NO_U;
    end else if (is_low1) begin
      status = u16e_pkg::ST_LONE_LOW;
    end else if (is_high1) begin
      if (st.char_count < u16e_pkg::LEN_PAIR || !st.second_prefix_ok) begin
        status = u16e_pkg::ST_NO_SECOND;
      end else if (!is_low2) begin
        status = u16e_pkg::ST_BAD_SECOND;
      end else begin
        cp = u16e_pkg::PAIR_BIAS + {1'b0, code1[9:0], code2[9:0]};
      end
    end else begin
      cp = {5'd0, code1};
    end
    res.code_point = cp;
    res.status     = status;
  end

endmodule

`default_nettype wire

// ----- src/utf16_escape_parser.sv -----
// Top level of the UTF-16 escape parser: input register, per-character
// state update and result register. Uses u16e_pkg and u16e_eval.
//
//   channel | signals                      | payload     | transaction
//   in      | in_valid, in_ready, in_data  | in_item_t   | one character
//   out     | out_valid, out_ready, out_data | out_item_t | one decoded string
//
// One character is taken per cycle while the input does not stall. A character
// waits in the input register until it can be folded in; the state update and
// final checks sit between that register and the result register, so out_valid
// rises when the result for the last character of a string is loaded there.
// Synchronous reset clears the pipeline and the decoder state.
// While a result waits, characters that are not last keep flowing into the
// decoder state; only a last character held behind a waiting result stalls
// the input.
`default_nettype none

module utf16_escape_parser (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire u16e_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output u16e_pkg::out_item_t  out_data
);

  logic                  in_full;
  u16e_pkg::in_item_t    in_reg;
  u16e_pkg::dec_state_t  st;
  u16e_pkg::dec_state_t  st_next;
  u16e_pkg::out_item_t   res;
  logic                  adv;
  logic                  res_load;
  logic [4:0]            hv;
  logic [3:0]            pos;

  assign adv      = in_full && (!in_reg.last_char || !out_valid || out_ready);
  assign res_load = adv && in_reg.last_char;
  assign in_ready = !in_full || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_reg <= in_data;
    end
  end

  // State after folding in the registered character.
  always_comb begin
    st_next = st;
    pos     = st.char_count;
    hv      = u16e_pkg::hex_value(in_reg.char_byte);
    if (pos == u16e_pkg::POS_BSL1) begin
      if (in_reg.char_byte != u16e_pkg::CHAR_BACKSLASH) begin
        st_next.first_prefix_status = u16e_pkg::PFX_NO_BSL;
      end
    end else if (pos == u16e_pkg::POS_U1) begin
      if (st.first_prefix_status == u16e_pkg::PFX_OK &&
          in_reg.char_byte != u16e_pkg::CHAR_U) begin
        st_next.first_prefix_status = u16e_pkg::PFX_NO_U;
      end
    end else if (pos <= u16e_pkg::POS_HEX1_LAST) begin
      if (hv[4]) st_next.first_digit_bad = 1'b1;
      st_next.first_unit = {st.first_unit[11:0], hv[3:0]};
    end else if (pos == u16e_pkg::POS_BSL2) begin
      if (in_reg.char_byte != u16e_pkg::CHAR_BACKSLASH) st_next.second_prefix_ok = 1'b0;
    end else if (pos == u16e_pkg::POS_U2) begin
      if (in_reg.char_byte != u16e_pkg::CHAR_U) st_next.second_prefix_ok = 1'b0;
    end else if (pos <= u16e_pkg::POS_HEX2_LAST) begin
      if (hv[4]) st_next.second_digit_bad = 1'b1;
      st_next.second_unit = {st.second_unit[11:0], hv[3:0]};
    end
    if (st.char_count != u16e_pkg::COUNT_MAX) begin
      st_next.char_count = st.char_count + 4'd1;
    end
  end

  u16e_eval u_eval (
    .st  (st_next),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= u16e_pkg::STATE_RESET;
    end else if (res_load) begin
      st <= u16e_pkg::STATE_RESET;
    end else if (adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_load) begin
      out_data <= res;
    end
  end

  // Any failure status carries a zero code point.
  a_err_zero_cp: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != u16e_pkg::ST_OK |-> out_data.code_point == 21'd0)
    else $error("nonzero code point with failure status");

  // A successful result is never a surrogate code unit.
  a_ok_not_surrogate: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == u16e_pkg::ST_OK |->
      (out_data.code_point < 21'h0D800 || out_data.code_point > 21'h0DFFF))
    else $error("surrogate reported as code point");

  // The decoder state starts over after each string.
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    res_load |=> st.char_count == 4'd0 && st.second_prefix_ok &&
      st.first_prefix_status == u16e_pkg::PFX_OK)
    else $error("state not cleared after result");

  // The input stalls only behind a held last character.
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_full && in_reg.last_char && out_valid && !out_ready)
    else $error("unexpected input stall");

endmodule

`default_nettype wire
